[rtl/urh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package urh_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int SLOT_W      = $clog2(MAX_ENTRIES);
    // Counts and logical offsets that may reach MAX_ENTRIES itself.
    localparam int COUNT_W     = SLOT_W + 1;

    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_ENTRIES);

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_UNDO  = 2'd1,
        ACT_REDO  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_APPENDED  = 3'd0,
        ST_COALESCED = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_MOVED     = 3'd3,
        ST_REFUSED   = 3'd4,
        ST_CLEARED   = 3'd5
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        action_t     action;
        logic [31:0] pan_x;
        logic [31:0] pan_y;
        logic [31:0] zoom;
        logic [63:0] view_word;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] out_pan_x;
        logic [31:0] out_pan_y;
        logic [31:0] out_zoom;
        logic [63:0] out_view_word;
        logic        undo_possible;
        logic        redo_possible;
        logic [6:0]  entries_held;
    } result_t;

    typedef struct packed {
        logic [31:0] pan_x;
        logic [31:0] pan_y;
        logic [31:0] zoom;
        logic [63:0] view_word;
    } snap_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } mem_rd_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        snap_t             data;
    } mem_wr_t;

    // Physical slot of a logical offset from the oldest entry.
    // The sum stays below twice the depth, so one compare and subtract wraps it.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0]  oldest,
                                                  input logic [COUNT_W-1:0] logical);
        logic [COUNT_W-1:0] sum;
        sum = {1'b0, oldest} + logical;
        if (sum >= MAX_CNT)
        begin
            sum = sum - MAX_CNT;
        end
        return sum[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/urh_store.sv]
`timescale 1ns / 1ps
`default_nettype none

// Snapshot memory: one write port, one read port, registered read data.
module urh_store (
    input  wire               clk,
    input  wire urh_pkg::mem_rd_t rd,
    input  wire urh_pkg::mem_wr_t wr,
    output urh_pkg::snap_t    rd_data
);
    import urh_pkg::*;

    snap_t mem [MAX_ENTRIES];
    snap_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/undo_redo_history_ring.sv]
`timescale 1ns / 1ps
`default_nettype none

// Bounded undo/redo history of view snapshots (three camera words and one view
// word) kept in a circular snapshot memory of MAX_ENTRIES slots. When a request
// is accepted the memory is read at the slot the action needs (current entry
// for push, its neighbor for undo/redo); in the execute step that follows, the
// read data is compared, the memory is written back if needed, the cursor/count
// registers are updated and the result register is loaded. A new request is
// not taken until the execute step of the last one is done, as the memory read
// comes ahead of the compare-and-write step. cmd_stall is high during that
// execute step, and stays high while it waits for the result register to be
// freed by an earlier result being taken. Because the next read can only start
// after the write-back cycle, reads never overlap a pending write. Clear resets
// only the pointers and the run flag; slots are simply rewritten later.
module undo_redo_history_ring (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cmd_valid,
    output logic             cmd_stall,
    input  wire urh_pkg::cmd_t cmd,
    output logic             result_valid,
    input  wire              result_stall,
    output urh_pkg::result_t result
);
    import urh_pkg::*;

    state_t state_reg, state_next;

    // History pointers.
    logic [SLOT_W-1:0]  oldest_reg, oldest_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [SLOT_W-1:0]  cursor_reg, cursor_next;
    logic               run_reg, run_next;

    cmd_t    cmd_reg;
    result_t result_reg, result_next;
    logic    result_valid_reg;

    mem_rd_t mem_rd;
    mem_wr_t mem_wr;
    snap_t   rd_data;

    logic accept;
    logic out_free;
    logic exec_fire;

    logic [COUNT_W-1:0] cursor_ext;
    logic [COUNT_W-1:0] cursor_inc;
    logic [SLOT_W-1:0]  cur_slot;
    logic               cam_only;
    logic               same_cam;
    logic [COUNT_W-1:0] cursor_next_inc;

    urh_store u_store (
        .clk     (clk),
        .rd      (mem_rd),
        .wr      (mem_wr),
        .rd_data (rd_data)
    );

    assign out_free  = !result_valid_reg || !result_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign exec_fire = (state_reg == S_EXEC) && out_free;

    // ---------------- FSM ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_stall = (state_reg != S_IDLE);
    end

    // ---------------- Read issue (accept cycle) ----------------
    assign cursor_ext = {1'b0, cursor_reg};
    assign cursor_inc = cursor_ext + COUNT_W'(1);

    always_comb
    begin
        mem_rd.en   = accept;
        mem_rd.addr = slot_of(oldest_reg, cursor_ext);
        unique case (cmd.action)
            ACT_PUSH:  mem_rd.addr = slot_of(oldest_reg, cursor_ext);
            // At the oldest entry the read is wasted; undo is refused then.
            ACT_UNDO:  mem_rd.addr = slot_of(oldest_reg, cursor_ext - COUNT_W'(1));
            ACT_REDO:  mem_rd.addr = slot_of(oldest_reg, cursor_inc);
            ACT_CLEAR: mem_rd.addr = slot_of(oldest_reg, cursor_ext);
            default:   mem_rd.addr = slot_of(oldest_reg, cursor_ext);
        endcase
    end

    // ---------------- Execute (read data valid) ----------------
    assign cur_slot = slot_of(oldest_reg, cursor_ext);
    assign cam_only = (rd_data.view_word == cmd_reg.view_word);
    assign same_cam = (rd_data.pan_x == cmd_reg.pan_x) && (rd_data.pan_y == cmd_reg.pan_y)
                   && (rd_data.zoom == cmd_reg.zoom);

    always_comb
    begin
        oldest_next = oldest_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        run_next    = run_reg;

        mem_wr.en             = 1'b0;
        mem_wr.addr           = cur_slot;
        mem_wr.data.pan_x     = cmd_reg.pan_x;
        mem_wr.data.pan_y     = cmd_reg.pan_y;
        mem_wr.data.zoom      = cmd_reg.zoom;
        mem_wr.data.view_word = cmd_reg.view_word;

        result_next        = '0;
        result_next.status = ST_REFUSED;

        unique case (cmd_reg.action)
            ACT_PUSH:
            begin
                if (count_reg == '0)
                begin
                    // Empty history: snapshot becomes the only entry.
                    oldest_next        = '0;
                    count_next         = COUNT_W'(1);
                    cursor_next        = '0;
                    run_next           = 1'b0;
                    mem_wr.en          = 1'b1;
                    mem_wr.addr        = '0;
                    result_next.status = ST_APPENDED;
                end
                else if (cam_only && same_cam)
                begin
                    result_next.status = ST_DROPPED;
                end
                else if (cam_only && run_reg)
                begin
                    // Camera run open: replace the current entry in place.
                    mem_wr.en          = 1'b1;
                    mem_wr.addr        = cur_slot;
                    result_next.status = ST_COALESCED;
                end
                else
                begin
                    // Drop redo tail, then append after the cursor.
                    mem_wr.en = 1'b1;
                    if (cursor_inc < MAX_CNT)
                    begin
                        mem_wr.addr = slot_of(oldest_reg, cursor_inc);
                        count_next  = cursor_inc + COUNT_W'(1);
                        cursor_next = cursor_inc[SLOT_W-1:0];
                    end
                    else
                    begin
                        // Full: overwrite the oldest slot and advance it.
                        mem_wr.addr = oldest_reg;
                        oldest_next = slot_of(oldest_reg, COUNT_W'(1));
                        count_next  = MAX_CNT;
                        cursor_next = SLOT_W'(MAX_ENTRIES - 1);
                    end
                    run_next           = cam_only;
                    result_next.status = ST_APPENDED;
                end
            end
            ACT_UNDO:
            begin
                if ((count_reg != '0) && (cursor_reg != '0))
                begin
                    cursor_next        = cursor_reg - SLOT_W'(1);
                    run_next           = 1'b0;
                    result_next.status = ST_MOVED;
                end
            end
            ACT_REDO:
            begin
                if ((count_reg != '0) && (cursor_inc < count_reg))
                begin
                    cursor_next        = cursor_inc[SLOT_W-1:0];
                    run_next           = 1'b0;
                    result_next.status = ST_MOVED;
                end
            end
            ACT_CLEAR:
            begin
                oldest_next        = '0;
                count_next         = '0;
                cursor_next        = '0;
                run_next           = 1'b0;
                result_next.status = ST_CLEARED;
            end
            default:
            begin
                result_next.status = ST_REFUSED;
            end
        endcase

        if (result_next.status == ST_MOVED)
        begin
            result_next.out_pan_x     = rd_data.pan_x;
            result_next.out_pan_y     = rd_data.pan_y;
            result_next.out_zoom      = rd_data.zoom;
            result_next.out_view_word = rd_data.view_word;
        end

        cursor_next_inc           = {1'b0, cursor_next} + COUNT_W'(1);
        result_next.undo_possible = (count_next != '0) && (cursor_next != '0);
        result_next.redo_possible = (count_next != '0) && (cursor_next_inc < count_next);
        result_next.entries_held  = 7'(count_next);

        if (!exec_fire)
        begin
            mem_wr.en = 1'b0;
        end
    end

    // ---------------- Registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            oldest_reg       <= '0;
            count_reg        <= '0;
            cursor_reg       <= '0;
            run_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_fire)
            begin
                oldest_reg       <= oldest_next;
                count_reg        <= count_next;
                cursor_reg       <= cursor_next;
                run_reg          <= run_next;
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if (exec_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    // Entry count never exceeds the ring depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("entry count above depth");

    // With entries present, the cursor points inside the history.
    a_cursor_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> ({1'b0, cursor_reg} < count_reg))
        else $error("cursor beyond newest entry");

    // A new result only appears out of the execute step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result without execute step");

    // A clear result always reports an empty history.
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (result_reg.status == ST_CLEARED)) |->
        ((result_reg.entries_held == 7'd0) && !result_reg.undo_possible
         && !result_reg.redo_possible))
        else $error("clear left entries");
`endif

endmodule

`default_nettype wire
